// File: sv/px2x_pkg.sv
// ----------------------------------------------------------------------------
// px2x_pkg
// Shared types and constants of the 2x pixel-art upscaler.
// ----------------------------------------------------------------------------
package px2x_pkg;

	localparam int MAX_WIDTH_DEF = 4096;

	localparam int PIX_W      = 64;
	localparam int COL_W      = 12;
	localparam int ROW_W      = 16;
	localparam int IWIDTH_W   = 13;
	localparam int IHEIGHT_W  = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Line store window refill after a register write
	typedef enum logic [1:0] {
		FETCH_RUN,
		FETCH_CUR,
		FETCH_NEXT
	} fetch_state_t;

	// One source item together with its neighborhood
	typedef struct packed {
		pixel_t             px;
		pixel_t             e;
		pixel_t             b;
		pixel_t             d;
		pixel_t             f;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic               has_above;
		logic               last_row;
		logic               last_col;
		logic               border;
	} src_item_t;

endpackage

// File: sv/px2x_if.sv
// ----------------------------------------------------------------------------
// px2x_if
// Valid/ready channels of the upscaler: source pixels in, 2x2 blocks out.
// ----------------------------------------------------------------------------
interface px2x_in_if;
	import px2x_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface px2x_out_if;
	import px2x_pkg::*;

	logic             valid;
	logic             ready;
	pixel_t           out_top_left;
	pixel_t           out_top_right;
	pixel_t           out_bottom_left;
	pixel_t           out_bottom_right;
	logic [COL_W-1:0] block_col;
	logic [ROW_W-1:0] block_row;
	logic             frame_done;
	logic             last_of_run;

	modport source (
		output valid, output out_top_left, output out_top_right,
		output out_bottom_left, output out_bottom_right,
		output block_col, output block_row, output frame_done, output last_of_run,
		input ready
	);
	modport sink (
		input valid, input out_top_left, input out_top_right,
		input out_bottom_left, input out_bottom_right,
		input block_col, input block_row, input frame_done, input last_of_run,
		output ready
	);
endinterface

// File: sv/px2x_line_store.sv
// ----------------------------------------------------------------------------
// px2x_line_store
// Configuration registers, position counters and the two-row line store with
// a two-entry read-ahead window that supplies E, B and F for every item.
// ----------------------------------------------------------------------------
module px2x_line_store #(
	parameter int MAX_WIDTH = px2x_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [px2x_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [px2x_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             take,
	input  px2x_pkg::pixel_t                 px,
	output logic                             idle,
	output px2x_pkg::src_item_t              item
);
	import px2x_pkg::*;

	localparam int CNT_W = $clog2(MAX_WIDTH);
	localparam int EXT_W = ((CNT_W > IWIDTH_W) ? CNT_W : IWIDTH_W) + 1;
	localparam int CE_W  = (CNT_W > COL_W) ? CNT_W : COL_W;
	localparam int RW1   = ROW_W + 1;

	typedef logic [2*PIX_W-1:0] pair_t;   // {row above, row two above}

	function automatic logic ends_row(input logic [CNT_W-1:0] x,
	                                  input logic [IWIDTH_W-1:0] wnz);
		logic wide;
		logic cap;
		wide = (EXT_W'(x) + EXT_W'(1)) >= EXT_W'(wnz);
		cap  = (x == CNT_W'(MAX_WIDTH - 1));
		return wide || cap;
	endfunction

	logic [IWIDTH_W-1:0]  width_q;
	logic [IHEIGHT_W-1:0] height_q;
	logic [IWIDTH_W-1:0]  width_nz;
	logic [IHEIGHT_W-1:0] height_nz;

	logic [CNT_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [CNT_W-1:0]     nxt_col;
	logic [CNT_W-1:0]     nxt2_col;
	logic                 last_col;
	logic                 last_row;

	pair_t                store_mem [MAX_WIDTH];
	pair_t                rd_q;
	pair_t                win0_q;
	pair_t                win1;
	pair_t                fwd_data_q;
	pair_t                wr_pair;
	logic                 fwd_q;
	pixel_t               prev_e_q;

	fetch_state_t         state_q;
	fetch_state_t         state_d;
	logic                 rd_en;
	logic [CNT_W-1:0]     rd_addr;

	// Effective frame size
	assign width_nz  = (width_q == '0) ? IWIDTH_W'(1) : width_q;
	assign height_nz = (height_q == '0) ? IHEIGHT_W'(1) : height_q;

	assign last_col = ends_row(col_q, width_nz);
	assign nxt_col  = last_col ? '0 : col_q + CNT_W'(1);
	assign nxt2_col = ends_row(nxt_col, width_nz) ? '0 : nxt_col + CNT_W'(1);
	assign last_row = (RW1'(row_q) + RW1'(1)) >= RW1'(height_nz);

	// Window: win0 is the entry at the current column, win1 at the next one
	assign win1    = fwd_q ? fwd_data_q : rd_q;
	assign wr_pair = {px, win0_q[2*PIX_W-1:PIX_W]};

	assign item.px        = px;
	assign item.e         = win0_q[2*PIX_W-1:PIX_W];
	assign item.b         = win0_q[PIX_W-1:0];
	assign item.d         = prev_e_q;
	assign item.f         = win1[2*PIX_W-1:PIX_W];
	assign item.col       = COL_W'(CE_W'(col_q));
	assign item.row       = row_q;
	assign item.has_above = (row_q != '0);
	assign item.last_row  = last_row;
	assign item.last_col  = last_col;
	assign item.border    = (col_q == '0) || last_col || (row_q == ROW_W'(1));

	assign idle = (state_q == FETCH_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IWIDTH_W'(1);
			height_q <= IHEIGHT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[IWIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[IHEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			col_q <= nxt_col;
			if (last_col) begin
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FETCH_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = take;
		rd_addr = nxt2_col;
		unique case (state_q)
			FETCH_RUN: ;
			FETCH_CUR: begin
				rd_en   = 1'b1;
				rd_addr = col_q;
				state_d = FETCH_NEXT;
			end
			FETCH_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = nxt_col;
				state_d = FETCH_RUN;
			end
			default: state_d = FETCH_RUN;
		endcase
		if (cfg_we) begin
			state_d = FETCH_CUR;
		end
	end

	// Line store: shift the column on every item, read ahead two columns
	always_ff @(posedge clk) begin
		if (take) begin
			store_mem[col_q] <= wr_pair;
		end
		if (rd_en) begin
			rd_q <= store_mem[rd_addr];
		end
	end

	// Forward the entry written this cycle where the read-ahead hits it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (take) begin
			fwd_q <= (nxt2_col == col_q);
		end else if (state_q != FETCH_RUN) begin
			fwd_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fwd_data_q <= wr_pair;
			win0_q     <= (nxt_col == col_q) ? wr_pair : win1;
			prev_e_q   <= win0_q[2*PIX_W-1:PIX_W];
		end else if (state_q == FETCH_NEXT) begin
			win0_q <= rd_q;
		end
	end

endmodule

// File: sv/px2x_block_out.sv
// ----------------------------------------------------------------------------
// px2x_block_out
// Item register, Scale2x rule and the result register that drives the block
// channel; an item of the last row below row 0 yields two blocks.
// ----------------------------------------------------------------------------
module px2x_block_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  px2x_pkg::src_item_t  item,
	output logic                 free,
	px2x_out_if.source           blocks
);
	import px2x_pkg::*;

	src_item_t        item_s1;
	logic             valid_s1;
	logic             second_s1;

	logic             out_can;
	logic             none;
	logic             is_px_block;
	logic             is_last;
	logic             emit;
	logic             done;

	pixel_t           q_tl;
	pixel_t           q_tr;
	pixel_t           q_bl;
	pixel_t           q_br;
	pixel_t           r_tl;
	pixel_t           r_tr;
	pixel_t           r_bl;
	pixel_t           r_br;
	logic [ROW_W-1:0] r_row;

	logic             valid_q;
	pixel_t           tl_q;
	pixel_t           tr_q;
	pixel_t           bl_q;
	pixel_t           br_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             frame_done_q;
	logic             last_q;

	// Scale2x on the block one row up
	always_comb begin
		q_tl = item_s1.e;
		q_tr = item_s1.e;
		q_bl = item_s1.e;
		q_br = item_s1.e;
		if (!item_s1.border && (item_s1.b != item_s1.px) && (item_s1.d != item_s1.f)) begin
			if (item_s1.d == item_s1.b) q_tl = item_s1.d;
			if (item_s1.f == item_s1.b) q_tr = item_s1.f;
			if (item_s1.d == item_s1.px) q_bl = item_s1.d;
			if (item_s1.f == item_s1.px) q_br = item_s1.f;
		end
	end

	assign none        = !item_s1.has_above && !item_s1.last_row;
	assign is_px_block = second_s1 || !item_s1.has_above;
	assign is_last     = is_px_block || !item_s1.last_row;
	assign out_can     = !valid_q || blocks.ready;
	assign emit        = valid_s1 && !none && out_can;
	assign done        = valid_s1 && (none || (out_can && is_last));
	assign free        = !valid_s1 || done;

	assign r_tl  = is_px_block ? item_s1.px : q_tl;
	assign r_tr  = is_px_block ? item_s1.px : q_tr;
	assign r_bl  = is_px_block ? item_s1.px : q_bl;
	assign r_br  = is_px_block ? item_s1.px : q_br;
	assign r_row = is_px_block ? item_s1.row : item_s1.row - ROW_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			second_s1 <= 1'b0;
		end else if (load) begin
			valid_s1  <= 1'b1;
			second_s1 <= 1'b0;
		end else if (done) begin
			valid_s1  <= 1'b0;
			second_s1 <= 1'b0;
		end else if (emit) begin
			second_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (blocks.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tl_q         <= r_tl;
			tr_q         <= r_tr;
			bl_q         <= r_bl;
			br_q         <= r_br;
			col_q        <= item_s1.col;
			row_q        <= r_row;
			frame_done_q <= is_px_block && item_s1.last_col;
			last_q       <= is_last;
		end
	end

	assign blocks.valid            = valid_q;
	assign blocks.out_top_left     = tl_q;
	assign blocks.out_top_right    = tr_q;
	assign blocks.out_bottom_left  = bl_q;
	assign blocks.out_bottom_right = br_q;
	assign blocks.block_col        = col_q;
	assign blocks.block_row        = row_q;
	assign blocks.frame_done       = frame_done_q;
	assign blocks.last_of_run      = last_q;

endmodule

// File: sv/pixel_art_2x_upscaler.sv
// ----------------------------------------------------------------------------
// pixel_art_2x_upscaler
// Scale2x upscaler: source pixels in raster order, one 2x2 block per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   pixels carries one 64-bit source pixel per item in raster order; blocks
//   carries one 2x2 result block per item with its source column and row.
//   A block is sent when the pixel below it arrives; the last row sends its
//   own blocks at once, so a last-row item (below row 0) yields two blocks.
//   Row 0 of a frame taller than one row yields nothing.
//   A taken item goes through the item register and the result register.
//   Throughput: one item per cycle while blocks are taken; a two-block item
//   holds the item register until the single result register takes block two.
//   Registers image_width and image_height are written on cfg_we with
//   cfg_index/cfg_data; the user must write them only while the block is idle
//   (not enforced); ready is low while each write refills the read-ahead.
//   Reset clears the position counters and sets both registers to 1; the line
//   store itself holds no reset value and needs no clearing pass.
//   When the receiver stalls, the result register holds its block, the item
//   register fills, and ready drops until the stall clears.
// ----------------------------------------------------------------------------
module pixel_art_2x_upscaler #(
	parameter int MAX_WIDTH = px2x_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	px2x_in_if.sink                          pixels,
	px2x_out_if.source                       blocks,
	input  logic                             cfg_we,
	input  logic [px2x_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [px2x_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import px2x_pkg::*;

	logic      take;
	logic      store_idle;
	logic      s1_free;
	src_item_t item;

	// Take an item when the read-ahead is settled and the item register frees
	assign pixels.ready = store_idle && s1_free;
	assign take         = pixels.valid && pixels.ready;

	// Line store, counters and neighborhood fetch
	px2x_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.px        (pixels.pixel_in),
		.idle      (store_idle),
		.item      (item)
	);

	// Rule evaluation and result register
	px2x_block_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.item   (item),
		.free   (s1_free),
		.blocks (blocks)
	);

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x pixel-art upscaler. Pixels stream in over
// valid/ready, and every 2x2 block that comes out is compared field by field
// with a Scale2x line-store model kept inside the bench. A short table of
// hand-picked items comes first. Random frames follow under several
// back-pressure patterns.
// ----------------------------------------------------------------------------
module tb;
	import px2x_pkg::*;

	localparam int MAX_W          = MAX_WIDTH_DEF;
	localparam int SETTLE_CYCLES  = 4;     // latency plus the refill after a write
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int QUIET_LIMIT    = 2000;  // cycles with no item moving on either side
	localparam int ITEMS_PER_MODE = 175;

	// One 2x2 result block, in port order
	typedef struct packed {
		pixel_t           top_left;
		pixel_t           top_right;
		pixel_t           bottom_left;
		pixel_t           bottom_right;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             frame_done;
		logic             last_of_run;
	} block_t;

	typedef enum logic [1:0] {
		STEP_PIXEL,
		STEP_WIDTH,
		STEP_HEIGHT
	} step_kind_t;

	// One row of the directed table; want is used only where typed is set
	typedef struct packed {
		step_kind_t kind;
		pixel_t     value;
		logic       typed;
		block_t     want;
	} plan_step_t;

	typedef struct {
		int     item;
		block_t blk;
	} fixed_answer_t;

	localparam int PLAN_LEN = 35;

	// Directed part. Rows with a typed block are one-pixel frames: the pixel lands in
	// all four corners at column 0, row 0, and closes the frame.
	plan_step_t directed_plan [PLAN_LEN] = '{
		// straight out of reset: 1x1 frames, zero and all ones
		'{STEP_PIXEL, 64'h0, 1'b1, '{64'h0, 64'h0, 64'h0, 64'h0, 12'd0, 16'd0, 1'b1, 1'b1}},
		'{STEP_PIXEL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0, 16'd0, 1'b1, 1'b1}},
		// zero width and height behave as 1
		'{STEP_WIDTH, 64'd0, 1'b0, '0},
		'{STEP_HEIGHT, 64'd0, 1'b0, '0},
		'{STEP_PIXEL, 64'h8000_0000_0000_0001, 1'b1,
			'{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
			64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 12'd0, 16'd0, 1'b1, 1'b1}},
		// 3x3 frame: the center pixel takes its left neighbor in the top-left corner
		'{STEP_WIDTH, 64'd3, 1'b0, '0},
		'{STEP_HEIGHT, 64'd3, 1'b0, '0},
		'{STEP_PIXEL, 64'h1111_0000_0000_0011, 1'b0, '0},
		'{STEP_PIXEL, 64'h2222_0000_0000_0022, 1'b0, '0},
		'{STEP_PIXEL, 64'h1111_0000_0000_0011, 1'b0, '0},
		'{STEP_PIXEL, 64'h2222_0000_0000_0022, 1'b0, '0},
		'{STEP_PIXEL, 64'h3333_0000_0000_0033, 1'b0, '0},
		'{STEP_PIXEL, 64'h4444_0000_0000_0044, 1'b0, '0},
		'{STEP_PIXEL, 64'h1111_0000_0000_0011, 1'b0, '0},
		'{STEP_PIXEL, 64'h1111_0000_0000_0011, 1'b0, '0},
		'{STEP_PIXEL, 64'h1111_0000_0000_0011, 1'b0, '0},
		// tallest height, cut short mid-frame: row 2 becomes the last row
		'{STEP_WIDTH, 64'd2, 1'b0, '0},
		'{STEP_HEIGHT, 64'hFFFF, 1'b0, '0},
		'{STEP_PIXEL, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, '0},
		'{STEP_PIXEL, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, '0},
		'{STEP_PIXEL, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
		'{STEP_PIXEL, 64'h5555_5555_5555_5555, 1'b0, '0},
		'{STEP_HEIGHT, 64'd3, 1'b0, '0},
		'{STEP_PIXEL, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
		'{STEP_PIXEL, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
		// width shrunk mid-row: a column past the new width ends the row
		'{STEP_WIDTH, 64'd4, 1'b0, '0},
		'{STEP_HEIGHT, 64'd2, 1'b0, '0},
		'{STEP_PIXEL, 64'h0000_0000_0000_0001, 1'b0, '0},
		'{STEP_PIXEL, 64'h0000_0000_0000_0002, 1'b0, '0},
		'{STEP_PIXEL, 64'h0000_0000_0000_0003, 1'b0, '0},
		'{STEP_PIXEL, 64'h0000_0000_0000_0004, 1'b0, '0},
		'{STEP_PIXEL, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{STEP_PIXEL, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, '0},
		'{STEP_WIDTH, 64'd2, 1'b0, '0},
		'{STEP_PIXEL, 64'hC3C3_3C3C_C3C3_3C3C, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	px2x_in_if  in_ch ();
	px2x_out_if out_ch ();

	pixel_art_2x_upscaler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (in_ch),
		.blocks    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Model state: register copies, position counters and the two line stores
	logic [IWIDTH_W-1:0]  shadow_width  = IWIDTH_W'(1);
	logic [IHEIGHT_W-1:0] shadow_height = IHEIGHT_W'(1);
	int                   next_col      = 0;
	int                   next_row      = 0;
	bit [PIX_W-1:0]       line_above     [MAX_W];
	bit [PIX_W-1:0]       line_two_above [MAX_W];

	block_t        pending_blocks [$];   // blocks still owed by the block under test
	fixed_answer_t fixed_answers [$];    // hand-typed blocks, keyed by item number

	int items_taken   = 0;   // items accepted, counted by the monitor
	int items_sent    = 0;   // items accepted, counted by the driver
	int mismatches    = 0;
	int quiet_cycles  = 0;
	int in_idle_pct   = 0;
	int out_stall_pct = 0;
	int hold_asked    = 0;
	int hold_taken    = 0;
	int hold_left     = 0;

	task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
		if (mismatches < 40)
			$display("%0t ns: %s: expected %h, got %h", $time, field, want, got);
		mismatches++;
	endtask

	task automatic check_block(input block_t want, input block_t got);
		if (got.top_left !== want.top_left)
			report("out_top_left", want.top_left, got.top_left);
		if (got.top_right !== want.top_right)
			report("out_top_right", want.top_right, got.top_right);
		if (got.bottom_left !== want.bottom_left)
			report("out_bottom_left", want.bottom_left, got.bottom_left);
		if (got.bottom_right !== want.bottom_right)
			report("out_bottom_right", want.bottom_right, got.bottom_right);
		if (got.col !== want.col)
			report("block_col", 64'(want.col), 64'(got.col));
		if (got.row !== want.row)
			report("block_row", 64'(want.row), 64'(got.row));
		if (got.frame_done !== want.frame_done)
			report("frame_done", 64'(want.frame_done), 64'(got.frame_done));
		if (got.last_of_run !== want.last_of_run)
			report("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
	endtask

	// Advance the Scale2x model by one pixel and queue the blocks it releases.
	// A pixel below row 0 releases the block above it; a last-row pixel also
	// releases its own block straight away.
	function automatic void predict_blocks(input pixel_t px);
		int            w, h, c, r, n;
		bit            last_col, last_row, border;
		pixel_t        e, b, d, f;
		block_t        res [2];
		fixed_answer_t fixed;
		w = (shadow_width == 0) ? 1 : ((shadow_width > MAX_W) ? MAX_W : int'(shadow_width));
		h = (shadow_height == 0) ? 1 : int'(shadow_height);
		c = (next_col >= MAX_W) ? MAX_W - 1 : next_col;
		r = next_row;
		last_col = (c + 1 >= w);
		last_row = (r + 1 >= h);
		n = 0;

		// shift the line stores at this column
		e = line_above[c];
		b = line_two_above[c];
		line_two_above[c] = e;
		line_above[c] = px;

		if (r >= 1) begin
			res[n] = '{e, e, e, e, c[COL_W-1:0], ROW_W'(r - 1), 1'b0, 1'b0};
			border = (c == 0) || last_col || (r == 1);
			if (!border) begin
				d = line_two_above[c - 1];
				f = line_above[c + 1];
				// the rule applies only when above differs from below and left from right
				if (b != px && d != f) begin
					if (d == b) res[n].top_left = d;
					if (f == b) res[n].top_right = f;
					if (d == px) res[n].bottom_left = d;
					if (f == px) res[n].bottom_right = f;
				end
			end
			n++;
		end
		if (last_row) begin
			res[n] = '{px, px, px, px, c[COL_W-1:0], r[ROW_W-1:0], last_col, 1'b0};
			n++;
		end
		if (n > 0) begin
			res[n - 1].last_of_run = 1'b1;
			// a hand-typed answer stands in for the final block of its item
			if (fixed_answers.size() != 0 && fixed_answers[0].item == items_taken) begin
				fixed = fixed_answers.pop_front();
				res[n - 1] = fixed.blk;
			end
			for (int i = 0; i < n; i++)
				pending_blocks.push_back(res[i]);
		end

		if (last_col) begin
			next_col = 0;
			next_row = last_row ? 0 : ((r + 1) & 16'hFFFF);
		end else begin
			next_col = c + 1;
		end
	endfunction

	// Monitor: track register writes, predict on every accepted pixel, check
	// every accepted block, and watch for a stuck handshake.
	always @(posedge clk) begin
		block_t got;
		bit     in_take, out_take;
		if (arst_n) begin
			in_take  = in_ch.valid && in_ch.ready;
			out_take = out_ch.valid && out_ch.ready;
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: shadow_width = cfg_data[IWIDTH_W-1:0];
					REG_IMAGE_HEIGHT: shadow_height = cfg_data[IHEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (in_take) begin
				predict_blocks(in_ch.pixel_in);
				items_taken++;
			end
			if (out_take) begin
				got = '{out_ch.out_top_left, out_ch.out_top_right, out_ch.out_bottom_left,
					out_ch.out_bottom_right, out_ch.block_col, out_ch.block_row,
					out_ch.frame_done, out_ch.last_of_run};
				if (pending_blocks.size() == 0)
					report("block with nothing owed, col/row", 64'({got.col, got.row}), '0);
				else
					check_block(pending_blocks.pop_front(), got);
			end
			quiet_cycles = (in_take || out_take) ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("pixel_art_2x_upscaler: mismatch");
				$finish;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when the driver asks for one
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_asked) begin
			out_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_taken <= hold_asked;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	// Offer one pixel after a random gap and hold it until it is taken.
	// Leave valid high afterwards so back-to-back items see no bubble.
	task automatic send_pixel(input pixel_t px);
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_in <= px;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stop sending, wait until every owed block is out, then let a row-0 item
	// still in flight drain through.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One whole frame from counters at zero. Pixels come mostly from a small
	// palette so that neighbors often match and the rule fires. Optionally
	// rewrite the height at the start of a later row.
	task automatic send_frame(input int raw_w, input int raw_h, input bit change_height);
		logic [IWIDTH_W-1:0]  wfield;
		logic [IHEIGHT_W-1:0] hfield;
		int                   w, rows, r, change_at, new_h;
		pixel_t               palette [4];
		wfield = raw_w[IWIDTH_W-1:0];
		hfield = raw_h[IHEIGHT_W-1:0];
		w = (wfield == 0) ? 1 : ((wfield > MAX_W) ? MAX_W : int'(wfield));
		rows = (hfield == 0) ? 1 : int'(hfield);
		change_at = (change_height && rows > 1) ? $urandom_range(rows - 1, 1) : -1;
		foreach (palette[i])
			palette[i] = {$urandom, $urandom};
		drain();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wfield));
		write_reg(REG_IMAGE_HEIGHT, hfield);
		r = 0;
		while (r < rows) begin
			if (r == change_at) begin
				drain();
				new_h = $urandom_range(rows + 2, 0);
				write_reg(REG_IMAGE_HEIGHT, new_h[IHEIGHT_W-1:0]);
				// at or past the new last row, this row closes the frame
				rows = (new_h > r + 1) ? new_h : r + 1;
			end
			repeat (w)
				send_pixel(($urandom_range(99) < 85) ? palette[$urandom_range(3)]
					: {$urandom, $urandom});
			r++;
		end
	endtask

	initial begin
		int start, raw_w, raw_h, pick;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.pixel_in <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; register rows wait for the block to go idle
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == STEP_PIXEL) begin
				if (directed_plan[i].typed)
					fixed_answers.push_back('{items_sent, directed_plan[i].want});
				send_pixel(directed_plan[i].value);
			end else begin
				drain();
				write_reg((directed_plan[i].kind == STEP_WIDTH) ? REG_IMAGE_WIDTH
					: REG_IMAGE_HEIGHT, directed_plan[i].value[CFG_DATA_W-1:0]);
			end
		end

		// Random frames under four idling patterns: none, sender gaps,
		// receiver stalls, and a little of both
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
				1: begin in_idle_pct = 80; out_stall_pct = 0;  end
				2: begin in_idle_pct = 0;  out_stall_pct = 80; end
				default: begin in_idle_pct = 25; out_stall_pct = 25; end
			endcase
			start = items_sent;
			if (mode == 0) begin
				// empty the block first, then hold the receiver off while pixels
				// keep coming, so the block backs up
				drain();
				hold_asked++;
				send_frame(8, 6, 1'b0);
			end
			while (items_sent - start < ITEMS_PER_MODE) begin
				pick = $urandom_range(99);
				raw_w = (pick < 5) ? 0 : ((pick < 20) ? $urandom_range(40, 9)
					: $urandom_range(8, 1));
				raw_h = ($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1);
				send_frame(raw_w, raw_h, $urandom_range(9) == 0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("pixel_art_2x_upscaler: match");
		else
			$display("pixel_art_2x_upscaler: mismatch");
		$finish;
	end

endmodule
